// ===== hw/rtl/utfv_pkg.sv =====
`default_nettype none

package utfv_pkg;

  // Result kinds as they appear on the output channel.
  typedef enum logic [1:0] {
    KIND_DATA = 2'd0,
    KIND_DONE = 2'd1,
    KIND_BAD  = 2'd2
  } kind_e;

  // Code point arithmetic.
  localparam int unsigned CpW = 21;
  localparam logic [CpW-1:0] MinTwoByte   = 21'h00080;
  localparam logic [CpW-1:0] MinThreeByte = 21'h00800;
  localparam logic [CpW-1:0] MinFourByte  = 21'h10000;
  localparam logic [CpW-1:0] CpMax        = 21'h10FFFF;
  localparam logic [CpW-1:0] SurrogateLo  = 21'h0D800;
  localparam logic [CpW-1:0] SurrogateHi  = 21'h0DFFF;
  localparam logic [CpW-1:0] TagLo        = 21'hE0000;
  localparam logic [CpW-1:0] TagHi        = 21'hE007F;

  // Character lengths.
  localparam logic [2:0] LenNone  = 3'd0;
  localparam logic [2:0] LenTwo   = 3'd2;
  localparam logic [2:0] LenThree = 3'd3;
  localparam logic [2:0] LenFour  = 3'd4;

  // Number of bytes held for an open character.
  localparam int unsigned HeldDepth = 3;

  // Job queue between the front and the back.
  localparam int unsigned FifoDepth = 4;
  localparam int unsigned FifoPtrW  = $clog2(FifoDepth);
  localparam int unsigned FifoCntW  = $clog2(FifoDepth + 1);

  // One job: the results caused by one accepted request.
  typedef struct packed {
    logic [3:0][7:0] bytes;     // kept bytes in order, entry 0 first
    logic [2:0]      nbytes;    // number of kept bytes, 0 to 4
    logic            has_tail;  // a done or invalid marker follows the bytes
    kind_e           tail_kind;
  } job_t;

endpackage

`default_nettype wire

// ===== hw/rtl/utfv_if.sv =====
`default_nettype none

// Input channel: one document byte per request.
interface utfv_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       doc_last;

  modport source (output valid, output data_byte, output doc_last, input ready);
  modport sink   (input valid, input data_byte, input doc_last, output ready);
  modport mon    (input valid, input data_byte, input doc_last, input ready);
endinterface

// Output channel: one result per request.
interface utfv_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic [1:0] kind;
  logic       run_last;

  modport source (output valid, output out_byte, output kind, output run_last, input ready);
  modport sink   (input valid, input out_byte, input kind, input run_last, output ready);
  modport mon    (input valid, input out_byte, input kind, input run_last, input ready);
endinterface

`default_nettype wire

// ===== hw/rtl/utf8_validate_strip_tag_chars_top.sv =====
// Strict UTF-8 validator that drops Unicode tag characters (E0000 to E007F).
// Input channel in_i: one document byte per request, doc_last on the final byte.
// Output channel out_o: one result per request, kind data, done or invalid,
// run_last on the final result caused by one input byte.
// Bytes of a multi-byte character come out together when the character
// completes; an invalid document gives one invalid result and nothing more,
// a clean one ends with a done result.
// Throughput: one input byte per cycle while the job queue is not full.
// Output runs at one result per cycle while the receiver is ready; the
// four-entry job queue between decoder and output stage absorbs the burst
// of up to five results that one byte can cause. An accepted byte's job is
// queued first; its first result then loads into the free output register.
// When the receiver stalls, the output register holds its result, the queue
// fills, and in_i.ready drops once the queue is full.
// Reset clears the character state, the queue and the output valid; no
// result is pending after reset and the first byte starts a new document.
`default_nettype none

module utf8_validate_strip_tag_chars_top import utfv_pkg::*; (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  utfv_in_if.sink    in_i,
  utfv_out_if.source out_o
);

  logic push;
  logic pop;
  logic full;
  logic empty;
  job_t job_in;
  job_t job_out;

  utfv_front u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_i),
    .full_i (full),
    .push_o (push),
    .job_o  (job_in)
  );

  utfv_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .job_i   (job_in),
    .full_o  (full),
    .pop_i   (pop),
    .job_o   (job_out),
    .empty_o (empty)
  );

  utfv_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .job_i   (job_out),
    .empty_i (empty),
    .pop_o   (pop),
    .out_o   (out_o)
  );

endmodule

`default_nettype wire

// ===== hw/rtl/utfv_front.sv =====
`default_nettype none

module utfv_front import utfv_pkg::*; (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  utfv_in_if.sink    in_i,
  input  wire logic  full_i,
  output logic       push_o,
  output job_t       job_o
);

  logic [CpW-1:0] cp_q, cp_d;
  logic [2:0]     exp_q, exp_d;
  logic [2:0]     seen_q, seen_d;
  logic           failed_q, failed_d;
  logic [7:0]     held_q [HeldDepth];
  logic [7:0]     held_d [HeldDepth];

  logic           accept;
  logic [7:0]     b;
  logic           last;
  logic [CpW-1:0] cp_next;
  logic           value_bad;
  logic           is_tag;
  logic           bad;
  job_t           job;

  assign in_i.ready = !full_i;
  assign accept     = in_i.valid && !full_i;
  assign b          = in_i.data_byte;
  assign last       = in_i.doc_last;

  // Code point after folding in a continuation byte, and its checks.
  assign cp_next   = {cp_q[CpW-7:0], b[5:0]};
  assign value_bad = ((exp_q == LenTwo)   && (cp_next < MinTwoByte))   ||
                     ((exp_q == LenThree) && (cp_next < MinThreeByte)) ||
                     ((exp_q == LenFour)  && (cp_next < MinFourByte))  ||
                     (cp_next > CpMax) ||
                     ((cp_next >= SurrogateLo) && (cp_next <= SurrogateHi));
  assign is_tag    = (cp_next >= TagLo) && (cp_next <= TagHi);

  // Decode one byte against the open character and build its job.
  always_comb begin
    cp_d      = cp_q;
    exp_d     = exp_q;
    seen_d    = seen_q;
    failed_d  = failed_q;
    held_d    = held_q;
    bad       = 1'b0;
    job       = '0;
    job.tail_kind = KIND_DONE;

    if (failed_q) begin
      // Rest of a rejected document is dropped; its final byte resets.
      if (last) begin
        cp_d     = '0;
        exp_d    = LenNone;
        seen_d   = '0;
        failed_d = 1'b0;
      end
    end else begin
      if (exp_q == LenNone) begin
        if (!b[7]) begin
          job.bytes[0] = b;
          job.nbytes   = 3'd1;
        end else begin
          priority if (b[7:5] == 3'b110) begin
            cp_d  = CpW'(b[4:0]);
            exp_d = LenTwo;
          end else if (b[7:4] == 4'b1110) begin
            cp_d  = CpW'(b[3:0]);
            exp_d = LenThree;
          end else if (b[7:3] == 5'b11110) begin
            cp_d  = CpW'(b[2:0]);
            exp_d = LenFour;
          end else begin
            bad = 1'b1;
          end
          if (!bad) begin
            held_d[0] = b;
            seen_d    = 3'd1;
          end
        end
      end else if (b[7:6] != 2'b10) begin
        bad = 1'b1;
      end else if ((4'(seen_q) + 4'd1) < 4'(exp_q)) begin
        held_d[seen_q[1:0]] = b;
        seen_d = seen_q + 3'd1;
        cp_d   = cp_next;
      end else begin
        // Final byte of the character.
        if (value_bad) begin
          bad = 1'b1;
        end else if (!is_tag) begin
          job.bytes[0] = held_q[0];
          job.bytes[1] = (seen_q == 3'd1) ? b : held_q[1];
          job.bytes[2] = (seen_q == 3'd2) ? b : held_q[2];
          job.bytes[3] = b;
          job.nbytes   = seen_q + 3'd1;
        end
        cp_d   = '0;
        exp_d  = LenNone;
        seen_d = '0;
      end

      // A character still open at document end is truncated.
      if (!bad && last && (exp_d != LenNone)) begin
        bad = 1'b1;
      end

      if (bad) begin
        job.nbytes    = '0;
        job.has_tail  = 1'b1;
        job.tail_kind = KIND_BAD;
        cp_d     = '0;
        exp_d    = LenNone;
        seen_d   = '0;
        failed_d = !last;
      end else if (last) begin
        job.has_tail  = 1'b1;
        job.tail_kind = KIND_DONE;
      end
    end
  end

  assign push_o = accept && !failed_q && ((job.nbytes != '0) || job.has_tail);
  assign job_o  = job;

  // Character state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cp_q     <= '0;
      exp_q    <= LenNone;
      seen_q   <= '0;
      failed_q <= 1'b0;
    end else if (accept) begin
      cp_q     <= cp_d;
      exp_q    <= exp_d;
      seen_q   <= seen_d;
      failed_q <= failed_d;
    end
  end

  // Held bytes of the open character carry no reset.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      held_q <= held_d;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/utfv_fifo.sv =====
`default_nettype none

module utfv_fifo import utfv_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic push_i,
  input  job_t      job_i,
  output logic      full_o,
  input  wire logic pop_i,
  output job_t      job_o,
  output logic      empty_o
);

  job_t                mem_q [FifoDepth];
  logic [FifoPtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [FifoCntW-1:0] count_q;

  assign full_o  = (count_q == FifoCntW'(FifoDepth));
  assign empty_o = (count_q == '0);
  assign job_o   = mem_q[rd_ptr_q];

  // Job storage.
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= job_i;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + FifoPtrW'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + FifoPtrW'(1);
      end
      unique case ({push_i, pop_i})
        2'b10:   count_q <= count_q + FifoCntW'(1);
        2'b01:   count_q <= count_q - FifoCntW'(1);
        default: count_q <= count_q;
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/utfv_back.sv =====
`default_nettype none

module utfv_back import utfv_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  job_t      job_i,
  input  wire logic empty_i,
  output logic      pop_o,
  utfv_out_if.source out_o
);

  logic [2:0] idx_q, idx_d;
  logic [2:0] total;
  logic       is_last;
  logic       load;
  logic       valid_q;
  logic [7:0] byte_q, byte_d;
  kind_e      kind_q, kind_d;
  logic       run_last_q;

  // Walk through the results of the job at the queue head.
  assign total   = job_i.nbytes + 3'(job_i.has_tail);
  assign is_last = ((idx_q + 3'd1) == total);
  assign load    = !empty_i && (!valid_q || out_o.ready);
  assign pop_o   = load && is_last;
  assign idx_d   = is_last ? 3'd0 : (idx_q + 3'd1);

  always_comb begin
    if (idx_q < job_i.nbytes) begin
      byte_d = job_i.bytes[idx_q[1:0]];
      kind_d = KIND_DATA;
    end else begin
      byte_d = '0;
      kind_d = job_i.tail_kind;
    end
  end

  // Result index and output valid.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q   <= '0;
      valid_q <= 1'b0;
    end else begin
      if (load) begin
        idx_q   <= idx_d;
        valid_q <= 1'b1;
      end else if (out_o.ready) begin
        valid_q <= 1'b0;
      end
    end
  end

  // Output payload register.
  always_ff @(posedge clk_i) begin
    if (load) begin
      byte_q     <= byte_d;
      kind_q     <= kind_d;
      run_last_q <= is_last;
    end
  end

  assign out_o.valid    = valid_q;
  assign out_o.out_byte = byte_q;
  assign out_o.kind     = kind_q;
  assign out_o.run_last = run_last_q;

endmodule

`default_nettype wire

// ===== hw/rtl/utfv_chk.sv =====
`default_nettype none

module utfv_chk import utfv_pkg::*; (
  input wire logic       clk_i,
  input wire logic       rst_ni,
  input wire logic       out_valid_i,
  input wire logic       out_ready_i,
  input wire logic [7:0] out_byte_i,
  input wire logic [1:0] out_kind_i,
  input wire logic       out_run_last_i
);

  // A stalled result holds.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_byte_i) &&
      $stable(out_kind_i) && $stable(out_run_last_i))
    else $error("stalled result changed");

  // Done and invalid markers carry a zero byte and close their run.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (out_kind_i != KIND_DATA) |-> (out_byte_i == 8'd0) &&
      out_run_last_i && ((out_kind_i == KIND_DONE) || (out_kind_i == KIND_BAD)))
    else $error("bad marker result");

  // No result is shown once reset has been seen at an edge.
  assert property (@(posedge clk_i) !rst_ni |=> !out_valid_i)
    else $error("output valid during reset");

  // Nothing comes out in the cycle after reset is released.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(rst_ni) |-> !out_valid_i)
    else $error("output valid right after reset");

endmodule

bind utf8_validate_strip_tag_chars_top utfv_chk u_chk (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .out_valid_i    (out_o.valid),
  .out_ready_i    (out_o.ready),
  .out_byte_i     (out_o.out_byte),
  .out_kind_i     (out_o.kind),
  .out_run_last_i (out_o.run_last)
);

`default_nettype wire
